>>> hw/rtl/queue_latency_averager_defines.svh
// ----------------------------------------------------------------------------
// Queue latency averager assertion macros
// Shared property wrappers for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef QUEUE_LATENCY_AVERAGER_DEFINES_SVH
`define QUEUE_LATENCY_AVERAGER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QLA_ASSERT_SAME(name, c, r, ante, cons, msg) \
  name: assert property (@(posedge c) disable iff (!r) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define QLA_ASSERT_NEXT(name, c, r, ante, cons, msg) \
  name: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/qla_pkg.sv
// ----------------------------------------------------------------------------
// Queue latency averager package
// Types, codes and fixed widths shared by the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package qla_pkg;

  localparam int TS_W          = 32;
  localparam int SUM_W         = 48;
  localparam int AVG_W         = 40;
  localparam int CNT_W         = 8;
  localparam int MODE_W        = 2;
  localparam int STS_W         = 2;
  localparam int FRACTION_BITS = 8;
  localparam int STEP_W        = $clog2(SUM_W);

  localparam logic [CNT_W-1:0] WINDOW_RESET = 8'd16;
  localparam logic [CNT_W-1:0] COUNT_MAX    = 8'd255;

  typedef enum logic [MODE_W-1:0] {
    MODE_ENQ    = 2'd0,
    MODE_DEQ    = 2'd1,
    MODE_REPORT = 2'd2
  } mode_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MEASURE,
    S_ACCUM,
    S_LOAD,
    S_DIV,
    S_COMMIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic measure;
    logic accum;
    logic div_load;
    logic div_step;
    logic commit;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic avg_req;
    logic div_last;
  } sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/qla_ctrl.sv
// ----------------------------------------------------------------------------
// Queue latency averager controller
// Sequences one item through measure, accumulate, divide (when an average is due) and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module qla_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire qla_pkg::sts_t sts,
  output qla_pkg::cmd_t      cmd
);

  qla_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= qla_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      qla_pkg::S_IDLE:    if (in_valid) state_nxt = qla_pkg::S_MEASURE;
      qla_pkg::S_MEASURE: state_nxt = qla_pkg::S_ACCUM;
      qla_pkg::S_ACCUM: begin
        state_nxt = sts.avg_req ? qla_pkg::S_LOAD : qla_pkg::S_DONE;
      end
      qla_pkg::S_LOAD:    state_nxt = qla_pkg::S_DIV;
      qla_pkg::S_DIV:     if (sts.div_last) state_nxt = qla_pkg::S_COMMIT;
      qla_pkg::S_COMMIT:  state_nxt = qla_pkg::S_DONE;
      qla_pkg::S_DONE:    if (out_free) state_nxt = qla_pkg::S_IDLE;
      default:            state_nxt = qla_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      qla_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      qla_pkg::S_MEASURE: cmd.measure  = 1'b1;
      qla_pkg::S_ACCUM:   cmd.accum    = 1'b1;
      qla_pkg::S_LOAD:    cmd.div_load = 1'b1;
      qla_pkg::S_DIV:     cmd.div_step = 1'b1;
      qla_pkg::S_COMMIT:  cmd.commit   = 1'b1;
      qla_pkg::S_DONE: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

>>> hw/rtl/qla_datapath.sv
// ----------------------------------------------------------------------------
// Queue latency averager datapath
// Timestamp FIFO, latency sample accumulator, serial divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module qla_datapath #(
  parameter int FIFO_DEPTH = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire qla_pkg::cmd_t               cmd,
  output qla_pkg::sts_t                    sts,
  input  wire logic [qla_pkg::MODE_W-1:0]  in_mode,
  input  wire logic [qla_pkg::TS_W-1:0]    in_now,
  input  wire logic                        cfg_wr_en,
  input  wire logic [qla_pkg::CNT_W-1:0]   cfg_wr_data,
  output logic [qla_pkg::STS_W-1:0]        out_status,
  output logic [qla_pkg::TS_W-1:0]         out_latency,
  output logic [qla_pkg::AVG_W-1:0]        out_average,
  output logic                             out_updated
);

  localparam int PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FILL_W = $clog2(FIFO_DEPTH + 1);
  localparam int SUM_W  = qla_pkg::SUM_W;
  localparam int AVG_W  = qla_pkg::AVG_W;
  localparam int CNT_W  = qla_pkg::CNT_W;
  localparam int TS_W   = qla_pkg::TS_W;
  localparam int STEP_W = qla_pkg::STEP_W;

  localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(FIFO_DEPTH);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

  logic [TS_W-1:0] mem [FIFO_DEPTH];

  logic [qla_pkg::MODE_W-1:0] mode_r, mode_nxt;
  logic [TS_W-1:0]            now_r, now_nxt;
  logic [TS_W-1:0]            rd_data_r;
  logic [PTR_W-1:0]           head_r, head_nxt, tail_r, tail_nxt;
  logic [FILL_W-1:0]          fill_r, fill_nxt;
  logic [CNT_W-1:0]           window_r, window_nxt;
  logic [qla_pkg::STS_W-1:0]  status_r, status_nxt;
  logic [TS_W-1:0]            latency_r, latency_nxt;
  logic                       sample_pend_r, sample_pend_nxt;
  logic                       report_req_r, report_req_nxt;
  logic                       updated_r, updated_nxt;
  logic [SUM_W-1:0]           sum_r, sum_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic [AVG_W-1:0]           avg_r, avg_nxt;
  logic [SUM_W-1:0]           quo_r, quo_nxt;
  logic [CNT_W-1:0]           rem_r, rem_nxt;
  logic [CNT_W-1:0]           divisor_r, divisor_nxt;
  logic [STEP_W-1:0]          step_r, step_nxt;
  logic                       mem_we;

  logic [SUM_W-1:0] sample;
  logic [SUM_W:0]   sum_wide;
  logic [CNT_W-1:0] count_inc;
  logic [CNT_W:0]   trial;
  logic             trial_ge;

  assign sample    = SUM_W'(latency_r) << qla_pkg::FRACTION_BITS;
  assign sum_wide  = {1'b0, sum_r} + {1'b0, sample};
  assign count_inc = (count_r == qla_pkg::COUNT_MAX) ? count_r : count_r + 1'b1;
  assign trial     = {rem_r, quo_r[SUM_W-1]};
  assign trial_ge  = trial >= {1'b0, divisor_r};

  assign sts.avg_req  = sample_pend_r ? (count_inc >= window_r) : report_req_r;
  assign sts.div_last = step_r == STEP_LAST;

  always_comb begin
    mode_nxt        = mode_r;
    now_nxt         = now_r;
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    fill_nxt        = fill_r;
    window_nxt      = cfg_wr_en ? cfg_wr_data : window_r;
    status_nxt      = status_r;
    latency_nxt     = latency_r;
    sample_pend_nxt = sample_pend_r;
    report_req_nxt  = report_req_r;
    updated_nxt     = updated_r;
    sum_nxt         = sum_r;
    count_nxt       = count_r;
    avg_nxt         = avg_r;
    quo_nxt         = quo_r;
    rem_nxt         = rem_r;
    divisor_nxt     = divisor_r;
    step_nxt        = step_r;
    mem_we          = 1'b0;

    if (cmd.capture) begin
      mode_nxt    = in_mode;
      now_nxt     = in_now;
      updated_nxt = 1'b0;
    end

    if (cmd.measure) begin
      status_nxt      = qla_pkg::STS_OK;
      latency_nxt     = '0;
      sample_pend_nxt = 1'b0;
      report_req_nxt  = 1'b0;
      case (mode_r)
        qla_pkg::MODE_ENQ: begin
          if (fill_r == FILL_FULL) begin
            status_nxt = qla_pkg::STS_FULL;
          end else begin
            mem_we   = 1'b1;
            tail_nxt = (tail_r == PTR_LAST) ? '0 : tail_r + 1'b1;
            fill_nxt = fill_r + 1'b1;
          end
        end
        qla_pkg::MODE_DEQ: begin
          if (fill_r == '0) begin
            status_nxt = qla_pkg::STS_EMPTY;
          end else begin
            latency_nxt     = now_r - rd_data_r;
            head_nxt        = (head_r == PTR_LAST) ? '0 : head_r + 1'b1;
            fill_nxt        = fill_r - 1'b1;
            sample_pend_nxt = 1'b1;
          end
        end
        qla_pkg::MODE_REPORT: begin
          report_req_nxt = (avg_r == '0) && (count_r != '0);
        end
        default: ;
      endcase
    end

    if (cmd.accum && sample_pend_r) begin
      sum_nxt   = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
      count_nxt = count_inc;
    end

    if (cmd.div_load) begin
      quo_nxt     = sum_r;
      rem_nxt     = '0;
      divisor_nxt = count_r;
      step_nxt    = '0;
    end

    if (cmd.div_step) begin
      rem_nxt  = trial_ge ? CNT_W'(trial - {1'b0, divisor_r}) : trial[CNT_W-1:0];
      quo_nxt  = {quo_r[SUM_W-2:0], trial_ge};
      step_nxt = step_r + 1'b1;
    end

    if (cmd.commit) begin
      avg_nxt     = quo_r[AVG_W-1:0];
      sum_nxt     = SUM_W'(quo_r[AVG_W-1:0]);
      count_nxt   = CNT_W'(1);
      updated_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail_r] <= now_r;
    end
    rd_data_r <= mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r        <= '0;
      tail_r        <= '0;
      fill_r        <= '0;
      window_r      <= qla_pkg::WINDOW_RESET;
      sample_pend_r <= 1'b0;
      report_req_r  <= 1'b0;
      updated_r     <= 1'b0;
      sum_r         <= '0;
      count_r       <= '0;
      avg_r         <= '0;
    end else begin
      head_r        <= head_nxt;
      tail_r        <= tail_nxt;
      fill_r        <= fill_nxt;
      window_r      <= window_nxt;
      sample_pend_r <= sample_pend_nxt;
      report_req_r  <= report_req_nxt;
      updated_r     <= updated_nxt;
      sum_r         <= sum_nxt;
      count_r       <= count_nxt;
      avg_r         <= avg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    now_r     <= now_nxt;
    status_r  <= status_nxt;
    latency_r <= latency_nxt;
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    divisor_r <= divisor_nxt;
    step_r    <= step_nxt;
    if (cmd.load_out) begin
      out_status  <= status_r;
      out_latency <= latency_r;
      out_average <= avg_r;
      out_updated <= updated_r;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/queue_latency_averager.sv
// ----------------------------------------------------------------------------
// Queue latency averager
// Sequence: accept, measure, accumulate, then, when the item averages, load the
// divider, run its one-bit-per-cycle restoring divide of the 48-bit sample sum
// and commit; last, hand the result off. A new item is accepted only after the last one reaches the result register.
// Reset: synchronous active-low rst_n clears FIFO pointers, sum, count,
// average and the result valid; window_size returns to 16.
// ----------------------------------------------------------------------------
`default_nettype none
`include "queue_latency_averager_defines.svh"

module queue_latency_averager #(
  parameter int FIFO_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,    // now_ms[31:0]
  input  wire logic [1:0]  in_tuser,    // mode[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,   // latency_ms[31:0], average_time[71:32]
  output logic [2:0]       out_tuser,   // status[1:0], average_updated[2]
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data  // window_size[7:0]
);

  qla_pkg::cmd_t cmd;
  qla_pkg::sts_t sts;

  logic [qla_pkg::STS_W-1:0] res_status;
  logic [qla_pkg::TS_W-1:0]  res_latency;
  logic [qla_pkg::AVG_W-1:0] res_average;
  logic                      res_updated;

  qla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  qla_datapath #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_mode     (in_tuser),
    .in_now      (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_status  (res_status),
    .out_latency (res_latency),
    .out_average (res_average),
    .out_updated (res_updated)
  );

  assign out_tdata = {res_average, res_latency};
  assign out_tuser = {res_updated, res_status};

  `QLA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready,
    "input accepted again while an item is in progress")
  `QLA_ASSERT_SAME(a_empty_result, clk, rst_n,
    out_tvalid && (out_tuser[1:0] == qla_pkg::STS_EMPTY),
    (out_tdata[31:0] == 32'd0) && !out_tuser[2],
    "empty dequeue carries a latency or an average update")
  `QLA_ASSERT_SAME(a_full_result, clk, rst_n,
    out_tvalid && (out_tuser[1:0] == qla_pkg::STS_FULL),
    (out_tdata[31:0] == 32'd0) && !out_tuser[2],
    "dropped enqueue carries a latency or an average update")

endmodule

`default_nettype wire
